>>> rtl/core/psrl_pkg.sv
`default_nettype none

package psrl_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int USED_W        = 7;
   localparam int COUNT_W       = 25;
   localparam int LIMIT_W       = 24;
   localparam int TICK_W        = 32;
   localparam int ADDR_W        = 32;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // request opcodes
   localparam logic OP_CHECK   = 1'b0;
   localparam logic OP_CLEANUP = 1'b1;

   // response status codes
   localparam logic [1:0] ST_ALLOWED    = 2'd0;
   localparam logic [1:0] ST_OVER_LIMIT = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [1:0] ST_CLEANED    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_TICKS  = 2'd2;

   // register reset values
   localparam logic [LIMIT_W-1:0] RATE_LIMIT_RST   = '0;
   localparam logic [TICK_W-1:0]  WINDOW_TICKS_RST = 32'd1000;
   localparam logic [TICK_W-1:0]  STALE_TICKS_RST  = 32'd2000;

   typedef struct packed {
      logic [LIMIT_W-1:0] rate_limit;
      logic [TICK_W-1:0]  window_ticks;
      logic [TICK_W-1:0]  stale_ticks;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] count;
      logic [TICK_W-1:0]  start;
   } entry_type;

endpackage

`default_nettype wire

>>> rtl/core/psrl_csr.sv
`default_nettype none

module psrl_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [psrl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [psrl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output psrl_pkg::cfg_type                      cfg
);

   psrl_pkg::cfg_type cfg_ff, cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            psrl_pkg::CSR_RATE_LIMIT:
               cfg_in.rate_limit = csr_wdata[psrl_pkg::LIMIT_W-1:0];
            psrl_pkg::CSR_WINDOW_TICKS: cfg_in.window_ticks = csr_wdata;
            psrl_pkg::CSR_STALE_TICKS:  cfg_in.stale_ticks  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_limit   <= psrl_pkg::RATE_LIMIT_RST;
         cfg_ff.window_ticks <= psrl_pkg::WINDOW_TICKS_RST;
         cfg_ff.stale_ticks  <= psrl_pkg::STALE_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/per_source_fixed_window_rate_limiter_unit.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    op, source_addr, now_tick
// rsp_      out        rsp_valid/rsp_ready    status, entries_in_use
// csr_      in         csr_wr_en              csr_index, csr_wdata
//
// A check or cleanup request sweeps the entry memory, one entry a cycle
// through its single read port; a check that hits or finds a free slot
// then writes the entry back. A rate_limit zero check skips the sweep.
// Reset clears the valid bits and the in-use count; no clearing pass.
// A stalled response is held in the output register; the next request is
// taken meanwhile and waits at its end until the output register frees.

module per_source_fixed_window_rate_limiter_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_op,
   input  wire logic [psrl_pkg::ADDR_W-1:0]       req_source_addr,
   input  wire logic [psrl_pkg::TICK_W-1:0]       req_now_tick,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [1:0]                        rsp_status,
   output      logic [psrl_pkg::USED_W-1:0]       rsp_entries_in_use,
   input  wire logic                              csr_wr_en,
   input  wire logic [psrl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [psrl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DECIDE = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   psrl_pkg::cfg_type cfg;

   psrl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // control
   state_type                          state_ff, state_in;
   logic [psrl_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [psrl_pkg::USED_W-1:0]        used_ff, used_in;
   logic [psrl_pkg::IDX_W-1:0]         iss_idx_ff, iss_idx_in;
   logic                               iss_on_ff, iss_on_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic [psrl_pkg::IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                               hit_ff, hit_in;
   logic                               free_ff, free_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // payload
   logic                               op_ff, op_in;
   logic [psrl_pkg::ADDR_W-1:0]        src_ff, src_in;
   logic [psrl_pkg::TICK_W-1:0]        now_ff, now_in;
   logic [psrl_pkg::IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   psrl_pkg::entry_type                hit_ent_ff, hit_ent_in;
   logic [psrl_pkg::IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [1:0]                         res_ff, res_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic [psrl_pkg::USED_W-1:0]        rsp_used_ff, rsp_used_in;

   // entry memory
   psrl_pkg::entry_type mem [psrl_pkg::TABLE_ENTRIES];
   psrl_pkg::entry_type rd_data_ff;
   psrl_pkg::entry_type wr_data;
   logic [psrl_pkg::IDX_W-1:0] wr_idx;
   logic                       wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[iss_idx_ff];
   end

   logic [psrl_pkg::TICK_W-1:0]  age;
   logic [psrl_pkg::IDX_W-1:0]   dec_idx;
   logic [psrl_pkg::COUNT_W-1:0] dec_cnt;
   logic [psrl_pkg::COUNT_W-1:0] dec_cnt_inc;
   logic [psrl_pkg::TICK_W-1:0]  dec_start;
   logic [psrl_pkg::TICK_W-1:0]  hit_age;
   logic                         out_free;

   assign age         = now_ff - rd_data_ff.start;
   assign hit_age     = now_ff - hit_ent_ff.start;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE);

   // new window or fresh entry restarts the count
   always_comb begin
      if (!hit_ff) begin
         dec_idx   = free_idx_ff;
         dec_cnt   = '0;
         dec_start = now_ff;
      end else if (hit_age >= cfg.window_ticks) begin
         dec_idx   = hit_idx_ff;
         dec_cnt   = '0;
         dec_start = now_ff;
      end else begin
         dec_idx   = hit_idx_ff;
         dec_cnt   = hit_ent_ff.count;
         dec_start = hit_ent_ff.start;
      end
      dec_cnt_inc = (dec_cnt == psrl_pkg::COUNT_MAX) ? dec_cnt : dec_cnt + 1'b1;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      iss_idx_in    = iss_idx_ff;
      iss_on_in     = iss_on_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = iss_idx_ff;
      hit_in        = hit_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      op_in         = op_ff;
      src_in        = src_ff;
      now_in        = now_ff;
      hit_idx_in    = hit_idx_ff;
      hit_ent_in    = hit_ent_ff;
      free_idx_in   = free_idx_ff;
      res_in        = res_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      wr_en         = 1'b0;
      wr_idx        = dec_idx;
      wr_data.addr  = src_ff;
      wr_data.count = dec_cnt_inc;
      wr_data.start = dec_start;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               src_in     = req_source_addr;
               now_in     = req_now_tick;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               iss_idx_in = '0;
               if (req_op == psrl_pkg::OP_CHECK && cfg.rate_limit == '0) begin
                  res_in   = psrl_pkg::ST_ALLOWED;
                  state_in = S_FINISH;
               end else begin
                  iss_on_in = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue one read a cycle
            if (iss_on_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = iss_idx_ff;
               if (iss_idx_ff == psrl_pkg::LAST_IDX) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_idx_in = iss_idx_ff + 1'b1;
               end
            end
            // examine the returned entry
            if (rd_vld_ff) begin
               if (op_ff == psrl_pkg::OP_CLEANUP) begin
                  if (valid_ff[rd_idx_ff] && age > cfg.stale_ticks) begin
                     valid_in[rd_idx_ff] = 1'b0;
                     used_in             = used_ff - 1'b1;
                  end
               end else if (valid_ff[rd_idx_ff]) begin
                  if (!hit_ff && rd_data_ff.addr == src_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = rd_idx_ff;
                     hit_ent_in = rd_data_ff;
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == psrl_pkg::LAST_IDX) begin
                  if (op_ff == psrl_pkg::OP_CLEANUP) begin
                     res_in   = psrl_pkg::ST_CLEANED;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_DECIDE;
                  end
               end
            end
         end
         S_DECIDE: begin
            if (!hit_ff && !free_ff) begin
               res_in = psrl_pkg::ST_TABLE_FULL;
            end else begin
               wr_en = 1'b1;
               if (!hit_ff) begin
                  valid_in[free_idx_ff] = 1'b1;
                  used_in               = used_ff + 1'b1;
               end
               res_in = (dec_cnt_inc <= {1'b0, cfg.rate_limit}) ?
                        psrl_pkg::ST_ALLOWED : psrl_pkg::ST_OVER_LIMIT;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_ff;
               rsp_used_in   = used_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         used_ff      <= '0;
         iss_idx_ff   <= '0;
         iss_on_ff    <= 1'b0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         iss_idx_ff   <= iss_idx_in;
         iss_on_ff    <= iss_on_in;
         rd_vld_ff    <= rd_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      op_ff         <= op_in;
      src_ff        <= src_in;
      now_ff        <= now_in;
      hit_idx_ff    <= hit_idx_in;
      hit_ent_ff    <= hit_ent_in;
      free_idx_ff   <= free_idx_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entries_in_use = rsp_used_ff;

   // in-use count tracks the valid bits
   a_used_matches: assert property (@(posedge clock) disable iff (reset)
      used_ff == psrl_pkg::USED_W'($countones(valid_ff)))
      else $error("in-use count differs from valid bits");

   // a hit always names a valid entry
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && hit_ff) |-> valid_ff[hit_idx_ff])
      else $error("hit on invalid entry");

   // a free slot is never a valid entry at decision time
   a_free_invalid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && free_ff) |-> !valid_ff[free_idx_ff])
      else $error("free slot already valid");

   // memory is written only when a check resolves
   a_write_decide: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_DECIDE && op_ff == psrl_pkg::OP_CHECK))
      else $error("stray entry write");

endmodule

`default_nettype wire

>>> test/psrl_scoreboard.sv
`default_nettype none

// Watches the request, response and register channels, predicts each response from its own copy of the
// limiter table and compares it with what the block returns.
module psrl_scoreboard (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic                            req_op,
   input  wire logic [psrl_pkg::ADDR_W-1:0]     req_source_addr,
   input  wire logic [psrl_pkg::TICK_W-1:0]     req_now_tick,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [1:0]                      rsp_status,
   input  wire logic [psrl_pkg::USED_W-1:0]     rsp_entries_in_use,
   input  wire logic                            csr_wr_en,
   input  wire logic [psrl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [psrl_pkg::CSR_DATA_W-1:0] csr_wdata,
   output      int                              fail_count,
   output      int                              pending_count
);
   import psrl_pkg::*;

   localparam int RING_DEPTH = 16;

   typedef struct packed {
      logic [1:0]        status;
      logic [USED_W-1:0] used;
   } verdict_type;

   cfg_type           shadow_cfg;
   entry_type         shadow_tbl [TABLE_ENTRIES];
   logic              shadow_live [TABLE_ENTRIES];
   logic [USED_W-1:0] shadow_used;
   verdict_type       verdict_ring [RING_DEPTH];
   int                wr_cnt;
   int                rd_cnt;

   assign pending_count = wr_cnt - rd_cnt;

   // predict one request against the shadow table
   function automatic verdict_type limit_step(logic op, logic [ADDR_W-1:0] src,
                                              logic [TICK_W-1:0] now);
      verdict_type v;
      int hit;
      int free_slot;
      logic [TICK_W-1:0] age;
      hit = -1;
      free_slot = -1;
      if (op == OP_CLEANUP) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            age = now - shadow_tbl[i].start;
            if (shadow_live[i] && age > shadow_cfg.stale_ticks) begin
               shadow_live[i] = 1'b0;
               shadow_used--;
            end
         end
         v.status = ST_CLEANED;
      end else if (shadow_cfg.rate_limit == '0) begin
         v.status = ST_ALLOWED;
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (shadow_live[i]) begin
               if (hit < 0 && shadow_tbl[i].addr == src) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit < 0 && free_slot < 0) begin
            v.status = ST_TABLE_FULL;
         end else begin
            if (hit < 0) begin
               hit = free_slot;
               shadow_live[hit] = 1'b1;
               shadow_tbl[hit].addr = src;
               shadow_tbl[hit].count = '0;
               shadow_tbl[hit].start = now;
               shadow_used++;
            end else begin
               age = now - shadow_tbl[hit].start;
               if (age >= shadow_cfg.window_ticks) begin
                  shadow_tbl[hit].count = '0;
                  shadow_tbl[hit].start = now;
               end
            end
            if (shadow_tbl[hit].count != COUNT_MAX)
               shadow_tbl[hit].count++;
            v.status = ({7'd0, shadow_tbl[hit].count} <= {8'd0, shadow_cfg.rate_limit})
                       ? ST_ALLOWED : ST_OVER_LIMIT;
         end
      end
      v.used = shadow_used;
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      int errs;
      errs = 0;
      if (reset) begin
         shadow_cfg <= '{RATE_LIMIT_RST, WINDOW_TICKS_RST, STALE_TICKS_RST};
         for (int i = 0; i < TABLE_ENTRIES; i++) shadow_live[i] = 1'b0;
         shadow_used = '0;
         wr_cnt <= 0;
         rd_cnt <= 0;
         fail_count <= 0;
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RATE_LIMIT:   shadow_cfg.rate_limit <= csr_wdata[LIMIT_W-1:0];
               CSR_WINDOW_TICKS: shadow_cfg.window_ticks <= csr_wdata;
               CSR_STALE_TICKS:  shadow_cfg.stale_ticks <= csr_wdata;
               default: ;
            endcase
         end
         // compare before queueing a new request
         if (rsp_valid && rsp_ready) begin
            if (wr_cnt == rd_cnt) begin
               $error("unexpected response status=%0d used=%0d",
                      rsp_status, rsp_entries_in_use);
               errs++;
            end else begin
               want = verdict_ring[rd_cnt % RING_DEPTH];
               rd_cnt <= rd_cnt + 1;
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_entries_in_use !== want.used) begin
                  $error("entries_in_use: expected %0d, got %0d",
                         want.used, rsp_entries_in_use);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            verdict_ring[wr_cnt % RING_DEPTH] <=
               limit_step(req_op, req_source_addr, req_now_tick);
            wr_cnt <= wr_cnt + 1;
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

`default_nettype wire

>>> test/per_source_fixed_window_rate_limiter_unit_tb.sv
`default_nettype none

module per_source_fixed_window_rate_limiter_unit_tb;
   import psrl_pkg::*;

   localparam int CYCLE_LIMIT = 900000;
   localparam int DRAIN_CYCLES = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_op = OP_CHECK;
   logic [ADDR_W-1:0]     req_source_addr = '0;
   logic [TICK_W-1:0]     req_now_tick = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_status;
   logic [USED_W-1:0]     rsp_entries_in_use;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending_count;
   int                    cycle_count = 0;
   logic                  long_hold = 1'b0;

   // time base for generated requests and a small pool of sources
   logic [TICK_W-1:0] tick_now = '0;
   logic [ADDR_W-1:0] source_pool [80];

   always #6 clock = ~clock;

   per_source_fixed_window_rate_limiter_unit uut (.*);
   psrl_scoreboard checker_inst (.*);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("per_source_fixed_window_rate_limiter_unit verification failed");
         $finish;
      end
   end

   // receiver stall pattern, with one forced long hold-off
   always @(posedge clock) begin
      if (reset || long_hold) rsp_ready <= 1'b0;
      else if ((cycle_count / 500) % 3 == 0) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // one register write, then csr_wr_en drops again
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // offer one request and hold it until taken
   task automatic send_request(logic op, logic [ADDR_W-1:0] src, logic [TICK_W-1:0] now);
      req_valid <= 1'b1;
      req_op <= op;
      req_source_addr <= src;
      req_now_tick <= now;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random request, mostly checks on a recurring source set
   task automatic random_request(int pool_size);
      logic [ADDR_W-1:0] src;
      tick_now = tick_now + $urandom_range(0, 60);
      if ($urandom_range(0, 9) == 0) src = $urandom;
      else src = source_pool[$urandom_range(0, pool_size - 1)];
      if ($urandom_range(0, 19) == 0) send_request(OP_CLEANUP, $urandom, tick_now);
      else send_request(OP_CHECK, src, tick_now);
   endtask

   task automatic random_phase(int count, int pool_size);
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && sent < count; b++) begin
            random_request(pool_size);
            sent++;
         end
         if ($urandom_range(0, 1)) repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   initial begin
      for (int i = 0; i < 80; i++) source_pool[i] = $urandom;
      source_pool[0] = '0;
      source_pool[1] = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // limiting off at reset values
      send_request(OP_CHECK, 32'h0A000001, 32'd5);
      send_request(OP_CLEANUP, '0, 32'd10);
      wait_drained();

      // limit 2, window 100, stale 300: new source, over limit, window restart
      csr_write(CSR_RATE_LIMIT, 32'd2);
      csr_write(CSR_WINDOW_TICKS, 32'd100);
      csr_write(CSR_STALE_TICKS, 32'd300);
      send_request(OP_CHECK, '0, 32'd0);
      send_request(OP_CHECK, '0, 32'd10);
      send_request(OP_CHECK, '0, 32'd20);
      send_request(OP_CHECK, '1, 32'hFFFF_FFF0);
      send_request(OP_CHECK, '1, 32'd40);   // tick wrap, difference 0x38
      send_request(OP_CHECK, '0, 32'd100);  // window reached
      // fill the table, then an absent source is rejected
      for (int i = 0; i < 64; i++) send_request(OP_CHECK, 32'h1000 + i, 32'd150);
      send_request(OP_CHECK, 32'hDEAD_BEEF, 32'd151);
      send_request(OP_CLEANUP, '1, 32'd420);  // older than stale drop
      send_request(OP_CLEANUP, '0, 32'd460);
      wait_drained();

      // extremes: max limit, window of one, stale of one, then all ones
      csr_write(CSR_RATE_LIMIT, 32'hFFFFFF);
      csr_write(CSR_WINDOW_TICKS, 32'd1);
      csr_write(CSR_STALE_TICKS, 32'd1);
      tick_now = 32'd1000;
      random_phase(300, 20);
      long_hold <= 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            long_hold <= 1'b0;
         end
         random_phase(30, 20);
      join
      wait_drained();

      csr_write(CSR_WINDOW_TICKS, 32'hFFFF_FFFF);
      csr_write(CSR_STALE_TICKS, 32'hFFFF_FFFF);
      csr_write(CSR_RATE_LIMIT, 32'd1);
      random_phase(250, 80);
      wait_drained();

      csr_write(CSR_RATE_LIMIT, 32'd3);
      csr_write(CSR_WINDOW_TICKS, 32'd200);
      csr_write(CSR_STALE_TICKS, 32'd500);
      random_phase(450, 40);
      wait_drained();

      csr_write(CSR_RATE_LIMIT, 32'd0);
      random_phase(100, 40);
      wait_drained();
      csr_write(CSR_RATE_LIMIT, 32'd5);
      random_phase(150, 70);
      wait_drained();

      if (fail_count == 0)
         $display("per_source_fixed_window_rate_limiter_unit verification clean");
      else
         $display("per_source_fixed_window_rate_limiter_unit verification failed");
      $finish;
   end
endmodule

`default_nettype wire

>>> per_source_fixed_window_rate_limiter_unit.f
rtl/core/psrl_pkg.sv
rtl/core/psrl_csr.sv
rtl/core/per_source_fixed_window_rate_limiter_unit.sv
test/psrl_scoreboard.sv
test/per_source_fixed_window_rate_limiter_unit_tb.sv
